/* rtl/core/riff_wave_header_parser_macros.svh */
// Assertion macros for the RIFF/WAVE header parser checker.
// Included by the checker file only.
`ifndef RIFF_WAVE_HEADER_PARSER_MACROS_SVH
`define RIFF_WAVE_HEADER_PARSER_MACROS_SVH

// Assert an implication under reset.
`define RWH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Assert an implication in the next cycle under reset.
`define RWH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/rwh_pkg.sv */
// Shared types and constants for the RIFF/WAVE header parser.
// No dependencies.
package rwh_pkg;

	typedef enum logic [2:0] {
		PH_PREAMBLE,
		PH_ID,
		PH_SIZE,
		PH_FMT,
		PH_SKIP
	} phase_t;

	typedef enum logic [1:0] {
		CT_BYTE,
		CT_DIV,
		CT_OUT
	} ctl_state_t;

	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_SHORT_PRE = 4'd1;
	localparam logic [3:0] ST_BAD_RIFF  = 4'd2;
	localparam logic [3:0] ST_BAD_WAVE  = 4'd3;
	localparam logic [3:0] ST_SHORT_SZ  = 4'd4;
	localparam logic [3:0] ST_FMT_SMALL = 4'd5;
	localparam logic [3:0] ST_SHORT_FMT = 4'd6;
	localparam logic [3:0] ST_MISSING   = 4'd7;
	localparam logic [3:0] ST_ZERO_ALN  = 4'd8;

	localparam logic [31:0] W_RIFF = 32'h52494646;
	localparam logic [31:0] W_WAVE = 32'h57415645;
	localparam logic [31:0] W_FMT  = 32'h666D7420;
	localparam logic [31:0] W_DATA = 32'h64617461;

	localparam int DivSteps = 32;

	// Commands from controller to datapath.
	typedef struct packed {
		logic step;      // consume one byte
		logic div_start; // load divider
		logic div_step;  // one quotient bit
		logic clear;     // back to reset state
	} dp_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic need_div;  // final byte left status ok
		logic div_last;  // divider on last bit
	} dp_sts_t;

endpackage

/* rtl/core/rwh_ctrl.sv */
// Controller for the RIFF/WAVE header parser: handshakes and sequencing.
// Depends on rwh_pkg.
module rwh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              is_final,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output rwh_pkg::dp_cmd_t  cmd,
	input  rwh_pkg::dp_sts_t  sts
);

	rwh_pkg::ctl_state_t state_q, state_d;
	logic acc;

	assign acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rwh_pkg::CT_BYTE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rwh_pkg::CT_BYTE: begin
				if (acc && is_final) begin
					state_d = sts.need_div ? rwh_pkg::CT_DIV : rwh_pkg::CT_OUT;
				end
			end
			rwh_pkg::CT_DIV: begin
				if (sts.div_last) begin
					state_d = rwh_pkg::CT_OUT;
				end
			end
			rwh_pkg::CT_OUT: begin
				if (out_ready) begin
					state_d = rwh_pkg::CT_BYTE;
				end
			end
			default: state_d = rwh_pkg::CT_BYTE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		cmd           = '0;
		unique case (state_q)
			rwh_pkg::CT_BYTE: begin
				in_ready      = 1'b1;
				cmd.step      = acc;
				cmd.div_start = acc && is_final;
			end
			rwh_pkg::CT_DIV: begin
				cmd.div_step = 1'b1;
			end
			rwh_pkg::CT_OUT: begin
				out_valid = 1'b1;
				cmd.clear = out_ready;
			end
			default: ;
		endcase
	end

endmodule

/* rtl/core/rwh_dp.sv */
// Datapath for the RIFF/WAVE header parser: parse state, fmt capture, divider.
// Depends on rwh_pkg.
module rwh_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        file_byte,
	input  logic              is_final,
	input  rwh_pkg::dp_cmd_t  cmd,
	output rwh_pkg::dp_sts_t  sts,
	output logic [3:0]        status_code,
	output logic [15:0]       format_tag,
	output logic [15:0]       channel_count,
	output logic [31:0]       sample_hz,
	output logic [31:0]       bytes_per_sec,
	output logic [15:0]       frame_bytes,
	output logic [15:0]       sample_bits,
	output logic [31:0]       payload_offset,
	output logic [31:0]       payload_size,
	output logic [31:0]       frame_count
);

	rwh_pkg::phase_t phase_q, phase_d;
	logic [31:0] pos_q, pos_d;
	logic [4:0]  idx_q, idx_d;
	logic [31:0] id_q, id_d;
	logic [31:0] size_q, size_d;
	logic [32:0] skip_q, skip_d;
	logic        pad_q, pad_d;
	logic [127:0] fmt_q, fmt_d;
	logic        fmt_seen_q, fmt_seen_d;
	logic        data_seen_q, data_seen_d;
	logic [31:0] off_q, off_d;
	logic [31:0] sz_q, sz_d;
	logic [3:0]  err_q, err_d, fin_err;
	logic [31:0] size_new;
	logic [3:0]  k;

	// divider
	logic [31:0] quo_q, dvd_q;
	logic [16:0] rem_q;
	logic [15:0] dvs_q;
	logic [4:0]  dcnt_q;
	logic [16:0] rem_sh;
	logic [16:0] rem_sub;

	assign size_new = {file_byte, size_q[31:8]};
	assign k = idx_q[3:0];

	// Byte parse next state
	always_comb begin
		phase_d     = phase_q;
		pos_d       = (pos_q == 32'hFFFF_FFFF) ? pos_q : pos_q + 32'd1;
		idx_d       = idx_q;
		id_d        = id_q;
		size_d      = size_q;
		skip_d      = skip_q;
		pad_d       = pad_q;
		fmt_d       = fmt_q;
		fmt_seen_d  = fmt_seen_q;
		data_seen_d = data_seen_q;
		off_d       = off_q;
		sz_d        = sz_q;
		err_d       = err_q;
		if (err_q == rwh_pkg::ST_OK) begin
			unique case (phase_q)
				rwh_pkg::PH_PREAMBLE: begin
					id_d = {id_q[23:0], file_byte};
					if (idx_q == 5'd3) begin
						size_d = id_d;
					end
					if (idx_q >= 5'd11) begin
						if (size_q != rwh_pkg::W_RIFF) begin
							err_d = rwh_pkg::ST_BAD_RIFF;
						end else if (id_d != rwh_pkg::W_WAVE) begin
							err_d = rwh_pkg::ST_BAD_WAVE;
						end
						phase_d = rwh_pkg::PH_ID;
						idx_d   = '0;
					end else begin
						idx_d = idx_q + 5'd1;
					end
				end
				rwh_pkg::PH_ID: begin
					id_d = {id_q[23:0], file_byte};
					if (idx_q >= 5'd3) begin
						phase_d = rwh_pkg::PH_SIZE;
						idx_d   = '0;
					end else begin
						idx_d = idx_q + 5'd1;
					end
				end
				rwh_pkg::PH_SIZE: begin
					size_d = size_new;
					if (idx_q >= 5'd3) begin
						idx_d = '0;
						pad_d = size_new[0];
						if (id_q == rwh_pkg::W_FMT) begin
							if (size_new < 32'd16) begin
								err_d = rwh_pkg::ST_FMT_SMALL;
							end else begin
								skip_d  = {1'b0, size_new - 32'd16};
								phase_d = rwh_pkg::PH_FMT;
							end
						end else begin
							if (id_q == rwh_pkg::W_DATA) begin
								off_d       = pos_d;
								sz_d        = size_new;
								data_seen_d = 1'b1;
							end
							skip_d  = {1'b0, size_new};
							phase_d = (size_new == 32'd0) ? rwh_pkg::PH_ID : rwh_pkg::PH_SKIP;
						end
					end else begin
						idx_d = idx_q + 5'd1;
					end
				end
				rwh_pkg::PH_FMT: begin
					fmt_d[{k, 3'b000} +: 8] = file_byte;
					if (k == 4'd15) begin
						fmt_seen_d = 1'b1;
						idx_d      = '0;
						phase_d    = (skip_q == '0 && !pad_q) ? rwh_pkg::PH_ID
							: rwh_pkg::PH_SKIP;
					end else begin
						idx_d = {1'b0, k + 4'd1};
					end
				end
				rwh_pkg::PH_SKIP: begin
					if (skip_q != '0) begin
						skip_d = skip_q - 33'd1;
					end else begin
						pad_d = 1'b0;
					end
					if (skip_d == '0 && !pad_d) begin
						idx_d   = '0;
						phase_d = rwh_pkg::PH_ID;
					end
				end
				default: begin
					phase_d = rwh_pkg::PH_ID;
					idx_d   = '0;
				end
			endcase
		end
		// status on the final byte
		fin_err = err_d;
		if (err_d == rwh_pkg::ST_OK) begin
			if (phase_d == rwh_pkg::PH_PREAMBLE) begin
				fin_err = rwh_pkg::ST_SHORT_PRE;
			end else if (phase_d == rwh_pkg::PH_SIZE) begin
				fin_err = rwh_pkg::ST_SHORT_SZ;
			end else if (phase_d == rwh_pkg::PH_FMT) begin
				fin_err = rwh_pkg::ST_SHORT_FMT;
			end else if (!fmt_seen_d || !data_seen_d) begin
				fin_err = rwh_pkg::ST_MISSING;
			end else if (fmt_d[111:96] == 16'd0) begin
				fin_err = rwh_pkg::ST_ZERO_ALN;
			end
		end
		if (is_final) begin
			err_d = fin_err;
		end
	end

	assign sts.need_div = (fin_err == rwh_pkg::ST_OK);
	assign sts.div_last = (dcnt_q == 5'(rwh_pkg::DivSteps - 1));

	// Parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= rwh_pkg::PH_PREAMBLE;
			pos_q       <= '0;
			idx_q       <= '0;
			id_q        <= '0;
			size_q      <= '0;
			skip_q      <= '0;
			pad_q       <= 1'b0;
			fmt_q       <= '0;
			fmt_seen_q  <= 1'b0;
			data_seen_q <= 1'b0;
			off_q       <= '0;
			sz_q        <= '0;
			err_q       <= '0;
		end else if (cmd.clear) begin
			phase_q     <= rwh_pkg::PH_PREAMBLE;
			pos_q       <= '0;
			idx_q       <= '0;
			id_q        <= '0;
			size_q      <= '0;
			skip_q      <= '0;
			pad_q       <= 1'b0;
			fmt_q       <= '0;
			fmt_seen_q  <= 1'b0;
			data_seen_q <= 1'b0;
			off_q       <= '0;
			sz_q        <= '0;
			err_q       <= '0;
		end else if (cmd.step) begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			idx_q       <= idx_d;
			id_q        <= id_d;
			size_q      <= size_d;
			skip_q      <= skip_d;
			pad_q       <= pad_d;
			fmt_q       <= fmt_d;
			fmt_seen_q  <= fmt_seen_d;
			data_seen_q <= data_seen_d;
			off_q       <= off_d;
			sz_q        <= sz_d;
			err_q       <= err_d;
		end
	end

	// Restoring divider, one quotient bit per cycle
	assign rem_sh  = {rem_q[15:0], dvd_q[31]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.div_start) begin
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q <= sz_d;
			dvs_q <= fmt_d[111:96];
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (!rem_sub[16]) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	// Result fields, zero on error
	always_comb begin
		status_code    = err_q;
		format_tag     = '0;
		channel_count  = '0;
		sample_hz      = '0;
		bytes_per_sec  = '0;
		frame_bytes    = '0;
		sample_bits    = '0;
		payload_offset = '0;
		payload_size   = '0;
		frame_count    = '0;
		if (err_q == rwh_pkg::ST_OK) begin
			format_tag     = fmt_q[15:0];
			channel_count  = fmt_q[31:16];
			sample_hz      = fmt_q[63:32];
			bytes_per_sec  = fmt_q[95:64];
			frame_bytes    = fmt_q[111:96];
			sample_bits    = fmt_q[127:112];
			payload_offset = off_q;
			payload_size   = sz_q;
			frame_count    = quo_q;
		end
	end

endmodule

/* rtl/core/riff_wave_header_parser.sv */
// RIFF/WAVE header parser: one file byte per cycle while no result is pending, result on the final byte.
// Each byte is registered; the final byte of a good file also runs the bit-serial
// divider for frame_count, and error results come out the next cycle.
// Throughput: one byte per cycle while not finishing a file.
// Reset (arst_n low, async) returns to the preamble phase with the parse state clear;
// after each result the parser clears itself for the next file.
module riff_wave_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  file_byte,
	input  logic        is_final,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  status_code,
	output logic [15:0] format_tag,
	output logic [15:0] channel_count,
	output logic [31:0] sample_hz,
	output logic [31:0] bytes_per_sec,
	output logic [15:0] frame_bytes,
	output logic [15:0] sample_bits,
	output logic [31:0] payload_offset,
	output logic [31:0] payload_size,
	output logic [31:0] frame_count
);

	rwh_pkg::dp_cmd_t cmd;
	rwh_pkg::dp_sts_t sts;

	rwh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.is_final  (is_final),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	rwh_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.file_byte      (file_byte),
		.is_final       (is_final),
		.cmd            (cmd),
		.sts            (sts),
		.status_code    (status_code),
		.format_tag     (format_tag),
		.channel_count  (channel_count),
		.sample_hz      (sample_hz),
		.bytes_per_sec  (bytes_per_sec),
		.frame_bytes    (frame_bytes),
		.sample_bits    (sample_bits),
		.payload_offset (payload_offset),
		.payload_size   (payload_size),
		.frame_count    (frame_count)
	);

endmodule

/* rtl/core/rwh_checker.sv */
// Port-level checker for the RIFF/WAVE header parser, bound to the top level.
// Depends on riff_wave_header_parser_macros.svh and rwh_pkg.
`include "riff_wave_header_parser_macros.svh"

module rwh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        is_final,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  status_code,
	input logic [15:0] frame_bytes,
	input logic [31:0] frame_count
);

	// never take input while a result waits
	`RWH_ASSERT_IMP(a_no_overlap, out_valid, !in_ready, "input taken during result")
	// a non-final transaction produces no result
	`RWH_ASSERT_NEXT(a_no_spurious, in_valid && in_ready && !is_final, !out_valid, "spurious result")
	// result holds until taken
	`RWH_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(status_code), "result dropped")
	// ok status implies nonzero frame size
	`RWH_ASSERT_IMP(a_align, out_valid && status_code == rwh_pkg::ST_OK, frame_bytes != 16'd0, "zero align with ok")
	// error status zeroes the frame count
	`RWH_ASSERT_IMP(a_err_zero, out_valid && status_code != rwh_pkg::ST_OK, frame_count == 32'd0, "frames on error")

endmodule

bind riff_wave_header_parser rwh_checker u_rwh_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.is_final    (is_final),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status_code (status_code),
	.frame_bytes (frame_bytes),
	.frame_count (frame_count)
);

/* dv/tb_riff_wave_header_parser.sv */
// Testbench for riff_wave_header_parser: byte-stream stimulus of WAV files with checks.
// Depends on rwh_pkg and the riff_wave_header_parser RTL.
module tb_riff_wave_header_parser;
	import rwh_pkg::*;

	localparam int CycleLimit = 2000000;

	typedef struct packed {
		logic [3:0]  status;
		logic [15:0] fmt_code;
		logic [15:0] chans;
		logic [31:0] srate;
		logic [31:0] brate;
		logic [15:0] align;
		logic [15:0] bits;
		logic [31:0] offset;
		logic [31:0] size;
		logic [31:0] frames;
	} wav_info_t;

	// Directed table row: byte, final flag, optional typed-in status.
	typedef struct {
		logic [7:0] b;
		logic       fin;
		logic       has_status;
		logic [3:0] status;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  file_byte;
	logic        is_final;
	logic        out_valid;
	logic        out_ready;
	wav_info_t   got;

	int send_idle_pct;
	int recv_idle_pct;
	int mismatches;
	int cycles;
	wav_info_t info_queue[$];
	logic [7:0] byte_stream[$];
	logic       final_stream[$];

	// Predictor state
	phase_t      p_phase;
	logic [31:0] p_pos;
	logic [4:0]  p_idx;
	logic [31:0] p_id;
	logic [31:0] p_size;
	logic [32:0] p_skip;
	logic        p_pad;
	logic [7:0]  p_fmt[16];
	logic        p_fmt_seen;
	logic        p_data_seen;
	logic [31:0] p_off;
	logic [31:0] p_dsize;
	logic [3:0]  p_err;

	riff_wave_header_parser u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.file_byte(file_byte), .is_final(is_final),
		.out_valid(out_valid), .out_ready(out_ready),
		.status_code(got.status), .format_tag(got.fmt_code),
		.channel_count(got.chans), .sample_hz(got.srate),
		.bytes_per_sec(got.brate), .frame_bytes(got.align),
		.sample_bits(got.bits), .payload_offset(got.offset),
		.payload_size(got.size), .frame_count(got.frames)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void parser_clear();
		p_phase = PH_PREAMBLE;
		p_pos = '0;
		p_idx = '0;
		p_id = '0;
		p_size = '0;
		p_skip = '0;
		p_pad = 1'b0;
		foreach (p_fmt[i]) p_fmt[i] = '0;
		p_fmt_seen = 1'b0;
		p_data_seen = 1'b0;
		p_off = '0;
		p_dsize = '0;
		p_err = ST_OK;
	endfunction

	function automatic void enter_skip();
		p_idx = '0;
		p_phase = (p_skip == 0 && !p_pad) ? PH_ID : PH_SKIP;
	endfunction

	// Advance the parser by one byte; returns 1 with the file info on a final byte.
	function automatic bit parse_byte(input logic [7:0] b, input logic fin,
			output wav_info_t info);
		logic [15:0] aln;
		if (p_pos != 32'hFFFF_FFFF) p_pos++;
		if (p_err == ST_OK) begin
			case (p_phase)
				PH_PREAMBLE: begin
					p_id = {p_id[23:0], b};
					if (p_idx == 3) p_size = p_id;
					if (p_idx >= 11) begin
						if (p_size != W_RIFF) p_err = ST_BAD_RIFF;
						else if (p_id != W_WAVE) p_err = ST_BAD_WAVE;
						p_phase = PH_ID;
						p_idx = '0;
					end else p_idx++;
				end
				PH_ID: begin
					p_id = {p_id[23:0], b};
					if (p_idx >= 3) begin
						p_phase = PH_SIZE;
						p_idx = '0;
					end else p_idx++;
				end
				PH_SIZE: begin
					p_size = {b, p_size[31:8]};
					if (p_idx >= 3) begin
						p_idx = '0;
						p_pad = p_size[0];
						if (p_id == W_FMT) begin
							if (p_size < 16) p_err = ST_FMT_SMALL;
							else begin
								p_skip = {1'b0, p_size} - 33'd16;
								p_phase = PH_FMT;
							end
						end else begin
							if (p_id == W_DATA) begin
								p_off = p_pos;
								p_dsize = p_size;
								p_data_seen = 1'b1;
							end
							p_skip = {1'b0, p_size};
							enter_skip();
						end
					end else p_idx++;
				end
				PH_FMT: begin
					p_fmt[p_idx[3:0]] = b;
					if (p_idx[3:0] == 15) begin
						p_fmt_seen = 1'b1;
						enter_skip();
					end else p_idx = {1'b0, p_idx[3:0] + 4'd1};
				end
				PH_SKIP: begin
					if (p_skip > 0) p_skip--;
					else p_pad = 1'b0;
					if (p_skip == 0 && !p_pad) enter_skip();
				end
				default: begin
					p_phase = PH_ID;
					p_idx = '0;
				end
			endcase
		end
		info = '0;
		if (!fin) return 1'b0;
		aln = {p_fmt[13], p_fmt[12]};
		if (p_err == ST_OK) begin
			if (p_phase == PH_PREAMBLE) p_err = ST_SHORT_PRE;
			else if (p_phase == PH_SIZE) p_err = ST_SHORT_SZ;
			else if (p_phase == PH_FMT) p_err = ST_SHORT_FMT;
			else if (!p_fmt_seen || !p_data_seen) p_err = ST_MISSING;
			else if (aln == 0) p_err = ST_ZERO_ALN;
		end
		info.status = p_err;
		if (p_err == ST_OK) begin
			info.fmt_code = {p_fmt[1], p_fmt[0]};
			info.chans = {p_fmt[3], p_fmt[2]};
			info.srate = {p_fmt[7], p_fmt[6], p_fmt[5], p_fmt[4]};
			info.brate = {p_fmt[11], p_fmt[10], p_fmt[9], p_fmt[8]};
			info.align = aln;
			info.bits = {p_fmt[15], p_fmt[14]};
			info.offset = p_off;
			info.size = p_dsize;
			info.frames = p_dsize / aln;
		end
		parser_clear();
		return 1'b1;
	endfunction

	// Queue helpers for building files
	function automatic void push_byte(input logic [7:0] b);
		byte_stream.push_back(b);
		final_stream.push_back(1'b0);
	endfunction

	function automatic void push_word_be(input logic [31:0] w);
		for (int i = 3; i >= 0; i--) push_byte(w[i*8 +: 8]);
	endfunction

	function automatic void push_word_le(input logic [31:0] w);
		for (int i = 0; i < 4; i++) push_byte(w[i*8 +: 8]);
	endfunction

	// Random file, mostly well-formed; may break it at random
	function automatic void build_file();
		int nchunks;
		int kind;
		logic [31:0] sz;
		logic [15:0] aln;
		push_word_be($urandom_range(0, 19) == 0 ? $urandom : W_RIFF);
		push_word_le($urandom);
		push_word_be($urandom_range(0, 19) == 0 ? $urandom : W_WAVE);
		nchunks = $urandom_range(0, 4);
		for (int c = 0; c < nchunks; c++) begin
			kind = $urandom_range(0, 9);
			if (kind < 4) begin
				push_word_be(W_FMT);
				sz = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 15) :
					16 + $urandom_range(0, ($urandom_range(0, 3) == 0) ? 5 : 0);
				push_word_le(sz);
				for (int i = 0; i < 16 && i < sz; i++) begin
					if (i == 12) begin
						aln = ($urandom_range(0, 9) == 0) ? 16'd0 :
							($urandom_range(0, 4) == 0 ? 16'($urandom) :
							16'($urandom_range(1, 8)));
						push_byte(aln[7:0]);
					end else if (i == 13) push_byte(aln[15:8]);
					else push_byte($urandom);
				end
				for (int i = 16; i < sz; i++) push_byte($urandom);
				if (sz[0] && sz >= 16) push_byte($urandom);
			end else begin
				push_word_be(kind < 8 ? W_DATA : $urandom);
				sz = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 24);
				push_word_le(sz);
				if (sz <= 24) begin
					for (int i = 0; i < sz + sz[0]; i++) push_byte($urandom);
				end
			end
		end
		// Random truncation sometimes, then mark the end
		if (byte_stream.size() > 0 && $urandom_range(0, 5) == 0) begin
			int cut;
			cut = $urandom_range(1, byte_stream.size());
			while (byte_stream.size() > cut) begin
				void'(byte_stream.pop_back());
				void'(final_stream.pop_back());
			end
		end
		if (byte_stream.size() == 0) push_byte($urandom);
		final_stream[final_stream.size() - 1] = 1'b1;
	endfunction

	// Drive one transaction and record the expected result
	task automatic send_byte(input logic [7:0] b, input logic fin, input logic has_st,
			input logic [3:0] st);
		wav_info_t info;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		file_byte <= b;
		is_final <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (parse_byte(b, fin, info)) begin
			if (has_st && info.status != st) begin
				mismatches++;
				if (mismatches <= 10)
					$display("table status %0d disagrees with predictor %0d", st, info.status);
			end
			info_queue.push_back(info);
		end
	endtask

	// Drop valid after the last transaction of a run
	task automatic release_input();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_stream();
		while (byte_stream.size() > 0)
			send_byte(byte_stream.pop_front(), final_stream.pop_front(), 1'b0, ST_OK);
		release_input();
	endtask

	// Receiver readiness
	always @(posedge clk) begin
		if (arst_n) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (info_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result status %0d", got.status);
			end else begin
				wav_info_t want;
				want = info_queue.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st=%0d fmt=%h ch=%h sr=%h br=%h al=%h bps=%h off=%h sz=%h fr=%h\n          got st=%0d fmt=%h ch=%h sr=%h br=%h al=%h bps=%h off=%h sz=%h fr=%h",
							want.status, want.fmt_code, want.chans, want.srate, want.brate,
							want.align, want.bits, want.offset, want.size, want.frames,
							got.status, got.fmt_code, got.chans, got.srate, got.brate,
							got.align, got.bits, got.offset, got.size, got.frames);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("FAIL riff_wave_header_parser");
			$finish;
		end
	end

	dir_row_t dir_rows[$];

	function automatic void add_row(input logic [7:0] b, input logic fin,
			input logic has_st, input logic [3:0] st);
		dir_row_t r;
		r.b = b;
		r.fin = fin;
		r.has_status = has_st;
		r.status = st;
		dir_rows.push_back(r);
	endfunction

	initial begin
		cycles = 0;
		mismatches = 0;
		send_idle_pct = 23;
		recv_idle_pct = 74;
		arst_n = 1'b0;
		in_valid = 1'b0;
		file_byte = '0;
		is_final = 1'b0;
		out_ready = 1'b0;
		parser_clear();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: short preamble, bad RIFF, bad WAVE, short size, fmt too small,
		// missing chunk, extreme byte values
		add_row(8'hFF, 1'b1, 1'b1, ST_SHORT_PRE);
		add_row(8'h00, 1'b1, 1'b1, ST_SHORT_PRE);
		for (int i = 0; i < 11; i++) add_row(8'h00, 1'b0, 1'b0, ST_OK);
		add_row(8'hFF, 1'b1, 1'b1, ST_BAD_RIFF);
		foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].fin,
			dir_rows[i].has_status, dir_rows[i].status);
		release_input();
		// Good preamble with wrong WAVE
		push_word_be(W_RIFF); push_word_le(32'hFFFF_FFFF); push_word_be(32'hFFFF_FFFF);
		final_stream[final_stream.size() - 1] = 1'b1;
		send_stream();
		// Preamble then end in a chunk ID: missing chunk
		push_word_be(W_RIFF); push_word_le(0); push_word_be(W_WAVE); push_byte(8'h64);
		final_stream[final_stream.size() - 1] = 1'b1;
		send_stream();
		// Final byte completes a chunk ID: short size
		push_word_be(W_RIFF); push_word_le(0); push_word_be(W_WAVE); push_word_be(W_DATA);
		final_stream[final_stream.size() - 1] = 1'b1;
		send_stream();
		// fmt chunk below 16 bytes
		push_word_be(W_RIFF); push_word_le(0); push_word_be(W_WAVE);
		push_word_be(W_FMT); push_word_le(15);
		final_stream[final_stream.size() - 1] = 1'b1;
		send_stream();
		// Full good file with extreme fields, skip past end of file
		push_word_be(W_RIFF); push_word_le(0); push_word_be(W_WAVE);
		push_word_be(W_FMT); push_word_le(17);
		for (int i = 0; i < 16; i++) push_byte(i == 12 ? 8'hFF : (i == 13 ? 8'hFF : 8'hFF));
		push_byte(8'h00); push_byte(8'h00);
		push_word_be(W_DATA); push_word_le(32'hFFFF_FFFF); push_byte(8'hAA);
		final_stream[final_stream.size() - 1] = 1'b1;
		send_stream();

		// Random files through three idling phases, with a drain pause in between
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				send_idle_pct = 74;
				recv_idle_pct = 23;
			end else if (ph == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int f = 0; f < 12; f++) begin
				build_file();
				send_stream();
			end
			while (info_queue.size() > 0) @(posedge clk);
		end

		while (info_queue.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && info_queue.size() == 0) begin
			$display("PASS riff_wave_header_parser");
		end else begin
			$display("FAIL riff_wave_header_parser");
		end
		$finish;
	end

endmodule
